// ----- design/stc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes, constants and the 16-segment font for the text scroller.
// Depends on nothing; every other file of the block imports it.
package stc_pkg;

  localparam int GLYPH_W = 16;
  localparam int TIME_W  = 32;
  localparam int STEP_W  = 16;
  localparam int ROT_W   = 4;
  localparam int CFG_W   = 16;
  localparam int CFG_IW  = 3;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  localparam logic [7:0]         CHAR_END        = 8'h00;
  localparam logic [GLYPH_W-1:0] BLANK_GLYPH     = 16'h0000;
  localparam logic [STEP_W-1:0]  RESET_REVEAL_MS = 16'd80;
  localparam logic [STEP_W-1:0]  RESET_SCROLL_MS = 16'd200;

  typedef enum logic [CFG_IW-1:0] {
    REG_GLYPH_ROTATE   = 3'd0,
    REG_REVEAL_STEP_MS = 3'd1,
    REG_SCROLL_STEP_MS = 3'd2,
    REG_GLYPH_SIX      = 3'd3,
    REG_GLYPH_LETTER_A = 3'd4,
    REG_GLYPH_LETTER_W = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic              opcode;
    logic [7:0]        char_code;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic       latch_after;
  } result_t;

  typedef struct packed {
    logic accept;
    logic emit_high;
    logic emit_low;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_needed;
    logic last_pair;
  } dp_status_t;

  // Characters without a pattern map to the blank glyph.
  function automatic logic [GLYPH_W-1:0] font_lookup(
    input logic [7:0]         ch,
    input logic [GLYPH_W-1:0] six,
    input logic [GLYPH_W-1:0] letter_a,
    input logic [GLYPH_W-1:0] letter_w
  );
    logic [GLYPH_W-1:0] g;
    case (ch)
      "0":     g = 16'h243F;
      "1":     g = 16'h0006;
      "2":     g = 16'h00DB;
      "3":     g = 16'h008F;
      "4":     g = 16'h12E0;
      "5":     g = 16'h00ED;
      "6":     g = six;
      "7":     g = 16'h0007;
      "8":     g = 16'h00FF;
      "9":     g = 16'h00EF;
      "A":     g = letter_a;
      "B":     g = 16'h128F;
      "C":     g = 16'h0039;
      "D":     g = 16'h120F;
      "E":     g = 16'h0079;
      "F":     g = 16'h0071;
      "G":     g = 16'h00BD;
      "H":     g = 16'h00F6;
      "I":     g = 16'h1209;
      "J":     g = 16'h001E;
      "K":     g = 16'h0C70;
      "L":     g = 16'h0038;
      "M":     g = 16'h0536;
      "N":     g = 16'h0936;
      "O":     g = 16'h003F;
      "P":     g = 16'h00F3;
      "Q":     g = 16'h083F;
      "R":     g = 16'h08F3;
      "S":     g = 16'h00ED;
      "T":     g = 16'h1201;
      "U":     g = 16'h003E;
      "V":     g = 16'h2430;
      "W":     g = letter_w;
      "X":     g = 16'h2D00;
      "Y":     g = 16'h1500;
      "Z":     g = 16'h2409;
      "*":     g = 16'h3FC0;
      default: g = BLANK_GLYPH;
    endcase
    return g;
  endfunction

  function automatic logic [GLYPH_W-1:0] rotate_left(
    input logic [GLYPH_W-1:0] g,
    input logic [ROT_W-1:0]   r
  );
    logic [2*GLYPH_W-1:0] wide;
    wide = {g, g} << r;
    return wide[2*GLYPH_W-1:GLYPH_W];
  endfunction

endpackage

// ----- design/stc_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the text scroller: accepts items and paces the byte run.
// Depends on stc_pkg for the command and status structs.
module stc_ctrl
  import stc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HIGH = 3'b010,
    S_LOW  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && status.run_needed) state_next = S_HIGH;
      end
      S_HIGH: state_next = S_LOW;
      S_LOW: begin
        state_next = status.last_pair ? S_IDLE : S_HIGH;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy          = (state != S_IDLE);
  assign cmd.accept    = start && (state == S_IDLE);
  assign cmd.emit_high = (state == S_HIGH);
  assign cmd.emit_low  = (state == S_LOW);

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && status.run_needed |=> state == S_HIGH)
    else $error("refresh run did not start after accept");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    state == S_HIGH |=> state == S_LOW)
    else $error("high byte not followed by low byte");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_LOW && status.last_pair |=> !busy)
    else $error("block stayed busy after the last pair");

endmodule

// ----- design/stc_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the text scroller: text memory, timing state, config registers,
// font lookup and the output byte register. Depends on stc_pkg.
module stc_dp
  import stc_pkg::*;
#(
  parameter int BUF_DEPTH = 32,
  parameter int DIGITS    = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  item_t             item,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              result_valid,
  output result_t           result
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int LW = $clog2(BUF_DEPTH + 1);
  localparam int SW = $clog2(BUF_DEPTH + DIGITS + 1);
  localparam int RW = $clog2(DIGITS + 1);
  localparam int PW = $clog2(DIGITS + 2);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_data;

  logic [LW-1:0]     write_index;
  logic [LW-1:0]     text_length;
  logic [RW-1:0]     reveal_count;
  logic [LW-1:0]     scroll_position;
  logic [TIME_W-1:0] last_step_time;

  logic [ROT_W-1:0]   glyph_rotate;
  logic [STEP_W-1:0]  reveal_step_ms;
  logic [STEP_W-1:0]  scroll_step_ms;
  logic [GLYPH_W-1:0] glyph_six;
  logic [GLYPH_W-1:0] glyph_letter_a;
  logic [GLYPH_W-1:0] glyph_letter_w;

  logic [SW-1:0]      slot;
  logic [SW-1:0]      slot_next;
  logic [PW-1:0]      blank_left;
  logic [PW-1:0]      pairs_left;
  logic [GLYPH_W-1:0] glyph;

  logic [TIME_W-1:0] elapsed;
  logic              is_short;
  logic              short_done;
  logic              long_done;
  logic              reveal_due;
  logic              scroll_due;
  logic [RW-1:0]     reveal_new;
  logic [LW-1:0]     scroll_limit;
  logic [LW-1:0]     scroll_inc;
  logic              is_refresh;
  logic              slot_blank;
  logic [GLYPH_W-1:0] glyph_now;

  assign elapsed    = item.now_ms - last_step_time;
  assign is_short   = 32'(text_length) <= 32'(DIGITS);
  assign short_done = 32'(reveal_count) >= 32'(DIGITS);
  assign long_done  = (32'(text_length) - 32'(scroll_position)) == 32'(DIGITS);
  assign reveal_due = elapsed > 32'(reveal_step_ms);
  assign scroll_due = elapsed > 32'(scroll_step_ms);
  assign reveal_new = reveal_due ? reveal_count + RW'(1) : reveal_count;
  assign scroll_limit = LW'(32'(text_length) - 32'(DIGITS));
  assign scroll_inc = scroll_position + LW'(1);
  assign is_refresh = (item.opcode == OP_REFRESH);

  assign status.run_needed = is_refresh && (is_short ? !short_done : !long_done);
  assign status.last_pair  = (pairs_left == PW'(1));

  // Leading blank pairs come first; a slot past the text reads as blank too.
  assign slot_blank = (blank_left != '0) || (32'(slot) >= 32'(text_length));
  assign glyph_now  = slot_blank ? BLANK_GLYPH :
                      rotate_left(font_lookup(rd_data, glyph_six, glyph_letter_a,
                                              glyph_letter_w), glyph_rotate);

  always_comb begin
    slot_next = slot;
    if (cmd.accept && status.run_needed) begin
      slot_next = is_short ? '0 : SW'(scroll_position);
    end else if (cmd.emit_low && blank_left == '0) begin
      slot_next = slot + SW'(1);
    end
  end

  // The read address follows the slot, so the data is ready for the next high byte.
  always_ff @(posedge clk) begin
    if (cmd.accept && !is_refresh && item.char_code != CHAR_END &&
        32'(write_index) < 32'(BUF_DEPTH)) begin
      mem[write_index[AW-1:0]] <= item.char_code;
    end
    rd_data <= mem[slot_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index     <= '0;
      text_length     <= '0;
      reveal_count    <= '0;
      scroll_position <= '0;
      last_step_time  <= '0;
      slot            <= '0;
      blank_left      <= '0;
      pairs_left      <= '0;
    end else begin
      slot <= slot_next;
      if (cmd.accept) begin
        if (!is_refresh) begin
          if (item.char_code == CHAR_END) begin
            text_length     <= write_index;
            reveal_count    <= '0;
            scroll_position <= '0;
            last_step_time  <= item.now_ms;
            write_index     <= '0;
          end else if (32'(write_index) < 32'(BUF_DEPTH)) begin
            write_index <= write_index + LW'(1);
          end
        end else if (status.run_needed) begin
          if (is_short) begin
            if (reveal_due) begin
              last_step_time <= item.now_ms;
              reveal_count   <= reveal_new;
            end
            blank_left <= PW'(DIGITS + 1) - PW'(reveal_new);
            pairs_left <= PW'(DIGITS + 1);
          end else begin
            if (scroll_due) begin
              last_step_time  <= item.now_ms;
              scroll_position <= (scroll_inc > scroll_limit) ? scroll_limit : scroll_inc;
            end
            blank_left <= '0;
            pairs_left <= PW'(DIGITS);
          end
        end
      end else if (cmd.emit_low) begin
        pairs_left <= pairs_left - PW'(1);
        if (blank_left != '0) blank_left <= blank_left - PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_rotate   <= '0;
      reveal_step_ms <= RESET_REVEAL_MS;
      scroll_step_ms <= RESET_SCROLL_MS;
      glyph_six      <= BLANK_GLYPH;
      glyph_letter_a <= BLANK_GLYPH;
      glyph_letter_w <= BLANK_GLYPH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GLYPH_ROTATE:   glyph_rotate   <= cfg_data[ROT_W-1:0];
        REG_REVEAL_STEP_MS: reveal_step_ms <= cfg_data;
        REG_SCROLL_STEP_MS: scroll_step_ms <= cfg_data;
        REG_GLYPH_SIX:      glyph_six      <= cfg_data;
        REG_GLYPH_LETTER_A: glyph_letter_a <= cfg_data;
        REG_GLYPH_LETTER_W: glyph_letter_w <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_high || cmd.emit_low;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_high) begin
      glyph              <= glyph_now;
      result.shift_byte  <= glyph_now[GLYPH_W-1:8];
      result.latch_after <= 1'b0;
    end else if (cmd.emit_low) begin
      result.shift_byte  <= glyph[7:0];
      result.latch_after <= (pairs_left == PW'(1));
    end
  end

  a_latch_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_low && pairs_left == PW'(1) |=> result_valid && result.latch_after)
    else $error("latch not marked on the last byte of a run");

  a_blanks_fit: assert property (@(posedge clk) disable iff (rst)
    blank_left <= pairs_left)
    else $error("more blank pairs pending than pairs left");

  a_scroll_bound: assert property (@(posedge clk) disable iff (rst)
    32'(text_length) > 32'(DIGITS) |->
      32'(scroll_position) <= 32'(text_length) - 32'(DIGITS))
    else $error("scroll position ran past the end of the text");

  a_reveal_bound: assert property (@(posedge clk) disable iff (rst)
    32'(reveal_count) <= 32'(DIGITS))
    else $error("reveal count above the digit count");

endmodule

// ----- design/segment_text_scroller.sv -----
`timescale 1ns / 1ps
// Top level of the 16-segment text scroller: joins sequencer and datapath.
// Depends on stc_pkg, stc_ctrl and stc_dp.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   item in  | start, busy          | item (opcode, char_code, now_ms)
//   result   | result_valid strobe  | result (shift_byte, latch_after)
//   config   | cfg_we               | cfg_index, cfg_data
//
// A load item never makes the block busy.
// A refresh is accepted and then sends its glyph pairs, high byte then low
// byte, through the single byte output register: DIGITS+1 pairs for a short
// text, DIGITS for a long one, and none when there is nothing to show.
// Each byte appears in the cycle after it is formed and stays for one cycle only.
// Reset is synchronous; the text memory is not cleared and needs no sweep.
module segment_text_scroller
  import stc_pkg::*;
#(
  parameter int BUF_DEPTH = 32,
  parameter int DIGITS    = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  item_t             item,
  output logic              result_valid,
  output result_t           result,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  stc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  stc_dp #(
    .BUF_DEPTH (BUF_DEPTH),
    .DIGITS    (DIGITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
